// ===== src/lsc_pkg.sv =====
// Shared constants, types and state encodings for the line sensor centroid block.
package lsc_pkg;

  localparam int FULL_SCALE   = 1000;
  localparam int SAMPLE_W     = 10;
  localparam int SUM_W        = 14;
  localparam int LVL_W        = 10;
  localparam int MAP_W        = 10;
  localparam int POS_W        = 13;
  localparam int IDX_W        = 2;
  localparam int MAX_SENSORS  = 8;
  localparam int LANE_NUM_W   = 24;  // |avg - white| * 1000
  localparam int WSUM_W       = 15;  // sum of v*i
  localparam int DEN_W        = 13;  // sum of v
  localparam int CNUM_W       = 25;  // sum of v*i*1000
  localparam int DEF_SENSORS  = 8;
  localparam int DEF_SAMPLES  = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_WHITE  = 2'd0,
    REG_BLACK  = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    T_ACC,
    T_START,
    T_MAP,
    T_MERGE,
    T_WAIT
  } top_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SUM,
    M_SCALE,
    M_DIV,
    M_DONE
  } merge_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lsc_stat_t;

endpackage

// ===== src/lsc_lane.sv =====
// One sensor lane: scan accumulator, average and serial mapping divider.
module lsc_lane import lsc_pkg::*; #(
  parameter int SAMPLES = DEF_SAMPLES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                add_en,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                start,
  input  logic [LVL_W-1:0]    white,
  input  logic [LVL_W-1:0]    black,
  output lsc_stat_t           stat,
  output logic [MAP_W-1:0]    mapped
);

  localparam int CNT_W = $clog2(LANE_NUM_W + 1);
  // exact reciprocal for sum / SAMPLES over the full sum range
  localparam int AVG_SH = SUM_W + $clog2(SAMPLES);
  localparam logic [SUM_W:0] AVG_MUL =
    (SUM_W + 1)'(((64'd1 << AVG_SH) + SAMPLES - 1) / SAMPLES);

  logic [SUM_W-1:0]      sum;
  logic [LVL_W-1:0]      rem;
  logic [LANE_NUM_W-1:0] quo;
  logic [LVL_W-1:0]      dm;
  logic                  neg;
  logic                  zero;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [2*SUM_W:0]      avg_prod;
  logic [SUM_W-1:0]      avg;
  logic [SUM_W:0]        diff;
  logic [SUM_W-1:0]      diff_mag;
  logic [LVL_W:0]        span;
  logic [LVL_W-1:0]      span_mag;
  logic [LANE_NUM_W-1:0] nm;
  logic [LVL_W:0]        rem_sh;
  logic                  fit;
  logic [LVL_W:0]        rem_nx;

  assign avg_prod = {{(SUM_W + 1){1'b0}}, sum} * {{SUM_W{1'b0}}, AVG_MUL};
  assign avg      = SUM_W'(avg_prod >> AVG_SH);
  assign diff     = {1'b0, avg} - {{(SUM_W + 1 - LVL_W){1'b0}}, white};
  assign diff_mag = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
  assign span     = {1'b0, black} - {1'b0, white};
  assign span_mag = span[LVL_W] ? LVL_W'(-span) : span[LVL_W-1:0];
  assign nm       = LANE_NUM_W'(diff_mag * FULL_SCALE);

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem, quo[LANE_NUM_W-1]};
  assign fit    = rem_sh >= {1'b0, dm};
  assign rem_nx = fit ? rem_sh - {1'b0, dm} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      sum  <= '0;
      quo  <= nm;
      rem  <= '0;
      dm   <= span_mag;
      neg  <= diff[SUM_W] ^ span[LVL_W];
      zero <= (span == '0);
      cnt  <= '0;
      busy <= 1'b1;
    end else begin
      if (add_en) begin
        sum <= sum + SUM_W'(sample);
      end
      if (busy) begin
        quo <= {quo[LANE_NUM_W-2:0], fit};
        rem <= rem_nx[LVL_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(LANE_NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(LANE_NUM_W - 1));
    end
  end

  always_comb begin
    if (zero || neg) begin
      mapped = '0;
    end else if (quo > LANE_NUM_W'(FULL_SCALE)) begin
      mapped = MAP_W'(FULL_SCALE);
    end else begin
      mapped = quo[MAP_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== src/lsc_merge.sv =====
// Merge stage: weighted sums over the lanes, centroid division, lost-line fallback.
module lsc_merge import lsc_pkg::*; #(
  parameter int SENSORS = DEF_SENSORS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LVL_W-1:0] thresh,
  input  logic [MAP_W-1:0] mapped [SENSORS],
  output lsc_stat_t        stat,
  output logic [POS_W-1:0] line_position,
  output logic             line_seen
);

  localparam int CNT_W = $clog2(CNUM_W + 1);
  localparam logic [POS_W-1:0] FAR  = POS_W'((SENSORS - 1) * FULL_SCALE);
  localparam logic [POS_W-1:0] HALF = POS_W'((SENSORS - 1) * FULL_SCALE / 2);

  merge_state_t state, state_next;

  logic [WSUM_W-1:0] wsum;
  logic [DEN_W-1:0]  den;
  logic              seen;
  logic              hit;
  logic [DEN_W-1:0]  rem;
  logic [CNUM_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic [POS_W-1:0]  last_position;

  logic [WSUM_W-1:0] wsum_c;
  logic [DEN_W-1:0]  den_c;
  logic              seen_c;
  logic [DEN_W:0]    rem_sh;
  logic              fit;
  logic [DEN_W:0]    rem_nx;

  always_comb begin
    wsum_c = '0;
    den_c  = '0;
    seen_c = 1'b0;
    for (int i = 0; i < SENSORS; i++) begin
      wsum_c = wsum_c + WSUM_W'(mapped[i] * i);
      den_c  = den_c + DEN_W'(mapped[i]);
      if (mapped[i] > thresh) begin
        seen_c = 1'b1;
      end
    end
  end

  assign rem_sh = {rem, quo[CNUM_W-1]};
  assign fit    = rem_sh >= {1'b0, den};
  assign rem_nx = fit ? rem_sh - {1'b0, den} : rem_sh;

  always_comb begin
    state_next = state;
    unique case (state)
      M_IDLE:  if (start) state_next = M_SUM;
      M_SUM:   state_next = M_SCALE;
      M_SCALE: state_next = (seen && den != '0) ? M_DIV : M_DONE;
      M_DIV:   if (cnt == CNT_W'(CNUM_W - 1)) state_next = M_DONE;
      M_DONE:  state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state != M_IDLE);
    stat.done = (state == M_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= M_IDLE;
      last_position <= '0;
      line_position <= '0;
      line_seen     <= 1'b0;
      cnt           <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        M_SUM: begin
          wsum <= wsum_c;
          den  <= den_c;
          seen <= seen_c;
        end
        M_SCALE: begin
          quo <= CNUM_W'(wsum * FULL_SCALE);
          rem <= '0;
          cnt <= '0;
          hit <= seen && den != '0;
        end
        M_DIV: begin
          quo <= {quo[CNUM_W-2:0], fit};
          rem <= rem_nx[DEN_W-1:0];
          cnt <= cnt + 1'b1;
        end
        M_DONE: begin
          if (hit) begin
            last_position <= quo[POS_W-1:0];
            line_position <= quo[POS_W-1:0];
            line_seen     <= 1'b1;
          end else begin
            line_position <= (last_position < HALF) ? '0 : FAR;
            line_seen     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/line_sensor_centroid.sv =====
// Top level of the line sensor centroid block: scan intake, lanes, merge, output register.
//
//   channel  | handshake         | payload
//   ---------+-------------------+---------------------------------------------
//   scan in  | s_tvalid/s_tready | s_tdata: sample_0 .. sample_7, 10 b each
//   result   | m_tvalid/m_tready | m_tdata: line_position; m_tuser: line_seen
//   config   | wr_en             | wr_index, wr_data (10 b)
//
// Scan requests are taken only in the accumulate state. After the SAMPLES-th scan
// the block stops taking scans while it runs a start state, the lane dividers
// (one quotient bit a cycle), the handoff, the merge sum and scale, the centroid
// division, the merge done state and the output load; the division is skipped
// when the line is lost. A stalled result waits in the output register while the
// next block's scans come in; a new result that finds it still full holds the
// block until it drains. Synchronous active-high reset.
module line_sensor_centroid import lsc_pkg::*; #(
  parameter int SENSORS = DEF_SENSORS,
  parameter int SAMPLES = DEF_SAMPLES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [MAX_SENSORS*SAMPLE_W-1:0]   s_tdata,  // sample_0 .. sample_7
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // line_position, zero pad
  output logic                              m_tuser,  // line_seen
  input  logic                              wr_en,
  input  logic [IDX_W-1:0]                  wr_index,
  input  logic [LVL_W-1:0]                  wr_data
);

  localparam int CNT_W = $clog2(SAMPLES + 1);

  top_state_t state, state_next;

  logic [LVL_W-1:0] white_level;
  logic [LVL_W-1:0] black_level;
  logic [LVL_W-1:0] line_threshold;
  logic [CNT_W-1:0] scan_count;

  logic             accept;
  logic             last_scan;
  logic             lane_start;
  logic             load;
  logic [SENSORS-1:0] lane_done;
  logic [MAP_W-1:0] mapped [SENSORS];
  lsc_stat_t        merge_stat;
  logic [POS_W-1:0] res_position;
  logic             res_seen;

  assign accept    = s_tvalid && s_tready;
  assign last_scan = (scan_count == CNT_W'(SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      white_level    <= LVL_W'(0);
      black_level    <= LVL_W'(1023);
      line_threshold <= LVL_W'(833);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_WHITE:  white_level    <= wr_data;
        REG_BLACK:  black_level    <= wr_data;
        REG_THRESH: line_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < SENSORS; i++) begin : g_lane
    lsc_stat_t lane_stat;

    lsc_lane #(.SAMPLES(SAMPLES)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .add_en (accept),
      .sample (s_tdata[i*SAMPLE_W +: SAMPLE_W]),
      .start  (lane_start),
      .white  (white_level),
      .black  (black_level),
      .stat   (lane_stat),
      .mapped (mapped[i])
    );

    assign lane_done[i] = lane_stat.done;
  end

  lsc_merge #(.SENSORS(SENSORS)) u_merge (
    .clk           (clk),
    .rst           (rst),
    .start         (lane_done[0]),
    .thresh        (line_threshold),
    .mapped        (mapped),
    .stat          (merge_stat),
    .line_position (res_position),
    .line_seen     (res_seen)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      T_ACC:   if (accept && last_scan) state_next = T_START;
      T_START: state_next = T_MAP;
      T_MAP:   if (lane_done[0]) state_next = T_MERGE;
      T_MERGE: if (merge_stat.done) state_next = T_WAIT;
      T_WAIT:  if (!m_tvalid || m_tready) state_next = T_ACC;
      default: state_next = T_ACC;
    endcase
  end

  always_comb begin
    s_tready   = (state == T_ACC);
    lane_start = (state == T_START);
    load       = (state == T_WAIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_ACC;
      scan_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        scan_count <= last_scan ? '0 : scan_count + 1'b1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{(16 - POS_W){1'b0}}, res_position};
      m_tuser <= res_seen;
    end
  end

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lane_done == {SENSORS{lane_done[0]}})
    else $error("lanes finished out of step");

  a_merge_done_state: assert property (@(posedge clk) disable iff (rst)
    merge_stat.done |-> state == T_MERGE)
    else $error("merge finished outside merge phase");

  a_result_from_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == T_WAIT)
    else $error("result raised outside wait phase");

  a_no_scan_in_compute: assert property (@(posedge clk) disable iff (rst)
    (lane_done[0] || merge_stat.busy) |-> !accept)
    else $error("scan request taken during compute");

endmodule

// ===== tb/line_sensor_centroid_checker.sv =====
// Checker for the line sensor centroid block: predicts positions from accepted scans.
`timescale 1ns / 1ps
module line_sensor_centroid_checker import lsc_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [MAX_SENSORS*SAMPLE_W-1:0] s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [15:0]                     m_tdata,
  input  logic                            m_tuser,
  input  logic                            wr_en,
  input  logic [IDX_W-1:0]                wr_index,
  input  logic [LVL_W-1:0]                wr_data,
  output int                              errors,
  output int                              pending,
  output int                              seen_count,
  output int                              lost_count
);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             seen;
  } position_t;

  localparam int FAR_END = (DEF_SENSORS - 1) * FULL_SCALE;

  logic [LVL_W-1:0] white_lvl, black_lvl, thresh;
  logic [SUM_W-1:0] sums [MAX_SENSORS];
  int               scans;
  logic [POS_W-1:0] last_pos;
  position_t        expected_q[$];

  assign pending = expected_q.size();

  function automatic longint map_avg(longint avg);
    longint w, b, v;
    w = white_lvl;
    b = black_lvl;
    if (b == w) return 0;
    v = (avg - w) * FULL_SCALE / (b - w);  // SV division truncates toward zero
    if (v > FULL_SCALE) v = FULL_SCALE;
    else if (v < 0) v = 0;
    return v;
  endfunction

  task automatic take_scan(input logic [MAX_SENSORS*SAMPLE_W-1:0] d);
    longint    v, num, den;
    bit        seen;
    position_t r;
    num = 0;
    den = 0;
    seen = 0;
    for (int i = 0; i < DEF_SENSORS; i++)
      sums[i] = sums[i] + SUM_W'(d[i*SAMPLE_W +: SAMPLE_W]);
    scans++;
    if (scans < DEF_SAMPLES) return;
    for (int i = 0; i < DEF_SENSORS; i++) begin
      v = map_avg(sums[i] / DEF_SAMPLES);
      if (v > thresh) seen = 1;
      num += v * i * FULL_SCALE;
      den += v;
    end
    if (seen && den > 0) begin
      last_pos = POS_W'(num / den);
      r.position = last_pos;
    end else begin
      seen = 0;
      r.position = (last_pos < FAR_END / 2) ? '0 : POS_W'(FAR_END);
    end
    r.seen = seen;
    expected_q.push_back(r);
    for (int i = 0; i < MAX_SENSORS; i++) sums[i] = '0;
    scans = 0;
  endtask

  always @(posedge clk) begin
    position_t e;
    if (rst) begin
      white_lvl <= '0;
      black_lvl <= LVL_W'(1023);
      thresh <= LVL_W'(833);
      for (int i = 0; i < MAX_SENSORS; i++) sums[i] = '0;
      scans = 0;
      last_pos = '0;
      expected_q.delete();
      errors <= 0;
      seen_count <= 0;
      lost_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result pos=%0d seen=%0b", $time, m_tdata, m_tuser);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata !== {3'b0, e.position} || m_tuser !== e.seen) begin
            $display("%0t: mismatch expected pos=%0d seen=%0b, actual pos=%0d seen=%0b",
                     $time, e.position, e.seen, m_tdata, m_tuser);
            errors <= errors + 1;
          end
          if (e.seen) seen_count <= seen_count + 1;
          else lost_count <= lost_count + 1;
        end
      end
      if (s_tvalid && s_tready) take_scan(s_tdata);
      if (wr_en) begin
        case (wr_index)
          REG_WHITE:  white_lvl <= wr_data;
          REG_BLACK:  black_lvl <= wr_data;
          REG_THRESH: thresh <= wr_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_line_sensor_centroid.sv =====
// Top of the line sensor centroid testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_line_sensor_centroid;
  import lsc_pkg::*;

  logic                            clk, rst;
  logic                            s_tvalid, s_tready;
  logic [MAX_SENSORS*SAMPLE_W-1:0] s_tdata;
  logic                            m_tvalid, m_tready;
  logic [15:0]                     m_tdata;
  logic                            m_tuser;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_index;
  logic [LVL_W-1:0]                wr_data;
  int                              errors, pending, seen_count, lost_count;
  int                              scans_sent;
  bit                              calm;

  line_sensor_centroid dut (.*);

  line_sensor_centroid_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  // random result stalls; none once calm is set
  initial begin
    m_tready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input int val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= LVL_W'(val);
    @(negedge clk);
    wr_en <= 0;
    @(negedge clk);
  endtask

  // drops the scan request left up by the last send_scan and waits until no result is pending
  task automatic wait_drained();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_scan(input logic [MAX_SENSORS*SAMPLE_W-1:0] d);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    scans_sent++;
  endtask

  function automatic logic [MAX_SENSORS*SAMPLE_W-1:0] all_lanes(input int v);
    logic [MAX_SENSORS*SAMPLE_W-1:0] d;
    for (int i = 0; i < MAX_SENSORS; i++) d[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(v);
    return d;
  endfunction

  // a line under a few adjacent sensors, noise elsewhere
  function automatic logic [MAX_SENSORS*SAMPLE_W-1:0] line_scan(input int center);
    logic [MAX_SENSORS*SAMPLE_W-1:0] d;
    int gap;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      gap = (i > center) ? i - center : center - i;
      d[i*SAMPLE_W +: SAMPLE_W] = (gap == 0) ? SAMPLE_W'($urandom_range(850, 1023)) :
                                  (gap == 1) ? SAMPLE_W'($urandom_range(300, 1023)) :
                                               SAMPLE_W'($urandom_range(0, 200));
    end
    return d;
  endfunction

  function automatic logic [MAX_SENSORS*SAMPLE_W-1:0] rand_scan();
    logic [MAX_SENSORS*SAMPLE_W-1:0] d;
    for (int i = 0; i < MAX_SENSORS; i++) d[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
    return d;
  endfunction

  initial begin
    int c;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    wr_en = 0;
    wr_index = REG_WHITE;
    wr_data = '0;
    calm = 0;
    scans_sent = 0;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset calibration: all black, all white, line at each end
    repeat (4) send_scan(all_lanes(1023));
    repeat (4) send_scan(all_lanes(0));
    for (int k = 0; k < 4; k++) send_scan(line_scan(7));
    for (int k = 0; k < 4; k++) send_scan(line_scan(0));
    wait_drained();

    // equal levels, then inverted levels, then an unreachable threshold
    write_reg(REG_WHITE, 500);
    write_reg(REG_BLACK, 500);
    repeat (4) send_scan(rand_scan());
    wait_drained();
    write_reg(REG_WHITE, 1023);
    write_reg(REG_BLACK, 0);
    write_reg(REG_THRESH, 0);
    repeat (4) send_scan(all_lanes(0));
    wait_drained();
    write_reg(REG_WHITE, 0);
    write_reg(REG_BLACK, 1023);
    write_reg(REG_THRESH, 1000);
    repeat (4) send_scan(all_lanes(1023));
    wait_drained();
    write_reg(REG_THRESH, 1023);
    repeat (4) send_scan(all_lanes(1023));
    wait_drained();

    // random phases with different calibrations
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_WHITE, 0); write_reg(REG_BLACK, 1023);
                 write_reg(REG_THRESH, 833); end
        1: begin write_reg(REG_WHITE, $urandom_range(0, 300));
                 write_reg(REG_BLACK, $urandom_range(700, 1023));
                 write_reg(REG_THRESH, $urandom_range(200, 900)); end
        2: begin write_reg(REG_WHITE, 1023); write_reg(REG_BLACK, 0);
                 write_reg(REG_THRESH, $urandom_range(0, 500)); end
        3: begin write_reg(REG_WHITE, $urandom); write_reg(REG_BLACK, $urandom);
                 write_reg(REG_THRESH, $urandom_range(0, 1000)); end
        4: begin write_reg(REG_WHITE, 100); write_reg(REG_BLACK, 900);
                 write_reg(REG_THRESH, 0); end
        default: begin write_reg(REG_WHITE, 0); write_reg(REG_BLACK, 1023);
                 write_reg(REG_THRESH, 600); calm = 1; end
      endcase
      for (int b = 0; b < 34; b++) begin
        c = $urandom_range(0, 7);
        for (int k = 0; k < DEF_SAMPLES; k++)
          send_scan(($urandom_range(0, 4) == 0) ? rand_scan() : line_scan(c));
      end
      wait_drained();
    end

    $display("%0d scans sent, %0d positions with line seen, %0d remembered edges;",
             scans_sent, seen_count, lost_count);
    $display("calibrations covered equal, inverted, full-range and random levels.");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
src/lsc_pkg.sv
src/lsc_lane.sv
src/lsc_merge.sv
src/line_sensor_centroid.sv
tb/line_sensor_centroid_checker.sv
tb/tb_line_sensor_centroid.sv
